>>> hdl/mnrm_pkg.sv
// Shared types, constants and preset table of the MIDI note range mapper.
package mnrm_pkg;

  // Field widths
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned ENTRY_W = 4;
  localparam int unsigned RANGE_W = 8;
  localparam int unsigned MASK_W  = 9;

  localparam logic [MASK_W-1:0] MASK_RESET = 9'h1FF;

  // Command codes of an input word
  localparam logic CMD_NOTE_ON = 1'b0;
  localparam logic CMD_SELECT  = 1'b1;

  // Preset entries and their note ranges
  localparam int unsigned ENTRY_KICK  = 0;
  localparam int unsigned ENTRY_SNARE = 1;
  localparam int unsigned ENTRY_SMP_A = 3;
  localparam int unsigned ENTRY_SMP_B = 4;

  localparam logic [NOTE_W-1:0] KICK_NOTE   = 7'd84;
  localparam logic [NOTE_W-1:0] SNARE_NOTE  = 7'd83;
  localparam logic [NOTE_W-1:0] SMP_A_LOW   = 7'd72;
  localparam logic [NOTE_W-1:0] SMP_A_HIGH  = 7'd79;
  localparam logic [NOTE_W-1:0] SMP_B_LOW   = 7'd60;
  localparam logic [NOTE_W-1:0] SMP_B_HIGH  = 7'd67;
  localparam logic [NOTE_W-1:0] EMPTY_LOW   = 7'd127;
  localparam logic [NOTE_W-1:0] EMPTY_HIGH  = 7'd0;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture input word, restart scan
    logic learn;  // apply learn select or learn note
    logic step;   // evaluate current entry and advance
    logic flush;  // move pending trigger out as the last one
  } mnrm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic go_learn;     // word at the input is a select or a learn note
    logic hit;          // current scan entry matches the note
    logic pend_vld;     // a trigger waits in the pending stage
    logic out_can_load; // output register can take a word this cycle
    logic scan_last;    // current scan entry is the final one
  } mnrm_sts_t;

  // Reset low note of an entry
  function automatic logic [NOTE_W-1:0] preset_low(input int unsigned idx);
    logic [NOTE_W-1:0] v;
    unique case (idx)
      ENTRY_KICK:  v = KICK_NOTE;
      ENTRY_SNARE: v = SNARE_NOTE;
      ENTRY_SMP_A: v = SMP_A_LOW;
      ENTRY_SMP_B: v = SMP_B_LOW;
      default:     v = EMPTY_LOW;
    endcase
    return v;
  endfunction

  // Reset high note of an entry
  function automatic logic [NOTE_W-1:0] preset_high(input int unsigned idx);
    logic [NOTE_W-1:0] v;
    unique case (idx)
      ENTRY_KICK:  v = KICK_NOTE;
      ENTRY_SNARE: v = SNARE_NOTE;
      ENTRY_SMP_A: v = SMP_A_HIGH;
      ENTRY_SMP_B: v = SMP_B_HIGH;
      default:     v = EMPTY_HIGH;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/mnrm_ctrl.sv
// Controller state machine of the MIDI note range mapper.
module mnrm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mnrm_pkg::mnrm_sts_t sts,
  output mnrm_pkg::mnrm_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LEARN = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Drive commands from the current state
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    cmd.learn = (state_r == ST_LEARN);
    // hold the scan while a second hit finds the output register busy
    cmd.step  = (state_r == ST_SCAN) && !(sts.hit && sts.pend_vld && !sts.out_can_load);
    cmd.flush = (state_r == ST_FLUSH) && sts.pend_vld && sts.out_can_load;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.go_learn ? ST_LEARN : ST_SCAN;
        end
      end
      ST_LEARN: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (cmd.step && sts.scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_vld || sts.out_can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/mnrm_dp.sv
// Datapath of the MIDI note range mapper: range table, scan, pending and output stages.
module mnrm_dp #(
  parameter int unsigned NUM_ENTRIES = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  input  logic [mnrm_pkg::MASK_W-1:0]    cfg_voice_present_mask,
  // input word
  input  logic                           in_cmd,
  input  logic [mnrm_pkg::NOTE_W-1:0]    in_note,
  input  logic                           in_learn_mode,
  input  logic [mnrm_pkg::ENTRY_W-1:0]   in_entry_select,
  // result word
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mnrm_pkg::ENTRY_W-1:0]   out_entry,
  output logic [mnrm_pkg::NOTE_W-1:0]    out_note_offset,
  output logic [mnrm_pkg::RANGE_W-1:0]   out_note_range,
  output logic                           out_last,
  // controller link
  input  mnrm_pkg::mnrm_cmd_t            cmd,
  output mnrm_pkg::mnrm_sts_t            sts
);

  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
  localparam int unsigned MASK_EXT_W = 16;

  // range table
  logic [mnrm_pkg::NOTE_W-1:0] range_low_r  [NUM_ENTRIES];
  logic [mnrm_pkg::NOTE_W-1:0] range_high_r [NUM_ENTRIES];

  logic [mnrm_pkg::MASK_W-1:0]  mask_r;
  logic [mnrm_pkg::ENTRY_W-1:0] learn_entry_r;
  logic                         expect_high_r;

  // captured input word
  logic                         cmd_r;
  logic [mnrm_pkg::NOTE_W-1:0]  note_r;
  logic                         learn_mode_r;
  logic [mnrm_pkg::ENTRY_W-1:0] sel_r;

  logic [IDX_W-1:0] idx_r;

  // pending trigger
  logic                         pend_vld_r;
  logic [mnrm_pkg::ENTRY_W-1:0] pend_entry_r;
  logic [mnrm_pkg::NOTE_W-1:0]  pend_offset_r;
  logic [mnrm_pkg::RANGE_W-1:0] pend_range_r;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [mnrm_pkg::ENTRY_W-1:0] out_entry_r;
  logic [mnrm_pkg::NOTE_W-1:0]  out_offset_r;
  logic [mnrm_pkg::RANGE_W-1:0] out_range_r;
  logic                         out_last_r;

  logic [IDX_W-1:0]             rd_idx;
  logic [mnrm_pkg::NOTE_W-1:0]  lo_rd, hi_rd;
  logic [MASK_EXT_W-1:0]        mask_ext;
  logic                         present, hit, can_load, push;
  logic [mnrm_pkg::NOTE_W-1:0]  offset;
  logic [mnrm_pkg::RANGE_W-1:0] nrange;
  logic                         sel_ok, tbl_wr;
  logic [mnrm_pkg::NOTE_W-1:0]  wr_lo, wr_hi;

  // Read the table at the learn entry or the scan index
  assign rd_idx = cmd.learn ? learn_entry_r[IDX_W-1:0] : idx_r;
  assign lo_rd  = range_low_r[rd_idx];
  assign hi_rd  = range_high_r[rd_idx];

  // Match the current entry against the note
  assign mask_ext = {{(MASK_EXT_W - mnrm_pkg::MASK_W){1'b0}}, mask_r};
  assign present  = mask_ext[4'(idx_r)];
  assign hit      = present && (note_r >= lo_rd) && (note_r <= hi_rd);
  assign offset   = note_r - lo_rd;
  assign nrange   = {1'b0, hi_rd} - {1'b0, lo_rd} + 8'd1;

  assign can_load = !out_valid_r || out_ready;
  assign push     = (cmd.step && hit && pend_vld_r) || cmd.flush;

  always_comb begin
    sts.go_learn     = (in_cmd == mnrm_pkg::CMD_SELECT) || in_learn_mode;
    sts.hit          = hit;
    sts.pend_vld     = pend_vld_r;
    sts.out_can_load = can_load;
    sts.scan_last    = (idx_r == LAST_IDX);
  end

  // Work out learn updates
  assign sel_ok = learn_mode_r && ({1'b0, sel_r} < 5'(NUM_ENTRIES));
  assign tbl_wr = cmd.learn && (cmd_r == mnrm_pkg::CMD_NOTE_ON);

  always_comb begin
    if (!expect_high_r) begin
      wr_lo = note_r;
      wr_hi = note_r;
    end else if (lo_rd > note_r) begin
      wr_lo = note_r;
      wr_hi = lo_rd;
    end else begin
      wr_lo = lo_rd;
      wr_hi = note_r;
    end
  end

  // Range table and learn state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < NUM_ENTRIES; i++) begin
        range_low_r[i]  <= mnrm_pkg::preset_low(i);
        range_high_r[i] <= mnrm_pkg::preset_high(i);
      end
      learn_entry_r <= '0;
      expect_high_r <= 1'b0;
    end else if (tbl_wr) begin
      range_low_r[rd_idx]  <= wr_lo;
      range_high_r[rd_idx] <= wr_hi;
      expect_high_r        <= 1'b1;
    end else if (cmd.learn && sel_ok) begin
      learn_entry_r <= sel_r;
      expect_high_r <= 1'b0;
    end
  end

  // Voice mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= mnrm_pkg::MASK_RESET;
    end else if (cfg_valid) begin
      mask_r <= cfg_voice_present_mask;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r        <= in_cmd;
      note_r       <= in_note;
      learn_mode_r <= in_learn_mode;
      sel_r        <= in_entry_select;
    end
  end

  // Scan index: restart on load, advance on step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.step && (idx_r != LAST_IDX)) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Pending stage: hold the latest hit until the next one or the flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.flush) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.step && hit) begin
      pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      pend_entry_r  <= 4'(idx_r);
      pend_offset_r <= offset;
      pend_range_r  <= nrange;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_entry_r  <= pend_entry_r;
      out_offset_r <= pend_offset_r;
      out_range_r  <= pend_range_r;
      out_last_r   <= cmd.flush;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry       = out_entry_r;
  assign out_note_offset = out_offset_r;
  assign out_note_range  = out_range_r;
  assign out_last        = out_last_r;

endmodule

>>> hdl/midi_note_range_mapper_core.sv
// Top level of the MIDI note range mapper.
//
// Channel  Dir  Handshake               Word
// in_      in   in_valid / in_ready     cmd, note, learn_mode, entry_select
// out_     out  out_valid / out_ready   entry, note_offset, note_range, last
// cfg_     in   cfg_valid / cfg_ready   voice_present_mask (always ready)
//
// A note-on in play mode runs as capture, one step per table
// entry, and a flush that marks the last trigger held in the pending stage.
// A learn select or learn note runs as capture, then table update.
// A hit stalls the scan only while the pending stage and out_ both hold a word;
// the flush waits for out_. The next word is taken right after the flush.
// Reset is synchronous, active low, and loads the preset note ranges.
module midi_note_range_mapper_core #(
  parameter int unsigned NUM_ENTRIES = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mnrm_pkg::MASK_W-1:0]   cfg_voice_present_mask,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [mnrm_pkg::NOTE_W-1:0]   in_note,
  input  logic                          in_learn_mode,
  input  logic [mnrm_pkg::ENTRY_W-1:0]  in_entry_select,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mnrm_pkg::ENTRY_W-1:0]  out_entry,
  output logic [mnrm_pkg::NOTE_W-1:0]   out_note_offset,
  output logic [mnrm_pkg::RANGE_W-1:0]  out_note_range,
  output logic                          out_last
);

  mnrm_pkg::mnrm_cmd_t cmd;
  mnrm_pkg::mnrm_sts_t sts;

  assign cfg_ready = 1'b1;

  mnrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mnrm_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_voice_present_mask (cfg_voice_present_mask),
    .in_cmd                 (in_cmd),
    .in_note                (in_note),
    .in_learn_mode          (in_learn_mode),
    .in_entry_select        (in_entry_select),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_entry              (out_entry),
    .out_note_offset        (out_note_offset),
    .out_note_range         (out_note_range),
    .out_last               (out_last),
    .cmd                    (cmd),
    .sts                    (sts)
  );

endmodule

>>> sim/midi_note_range_mapper_core_test.sv
// Self-checking testbench of the MIDI note range mapper core.
`timescale 1ns / 100ps

localparam int unsigned TABLE_SIZE = 9;

localparam logic MODE_PLAY  = 1'b0;
localparam logic MODE_LEARN = 1'b1;

typedef struct packed {
  logic                        cmd;
  logic [mnrm_pkg::NOTE_W-1:0] note;
  logic                        learn;
  logic [mnrm_pkg::ENTRY_W-1:0] sel;
} in_word_t;

typedef struct packed {
  logic [mnrm_pkg::ENTRY_W-1:0] entry;
  logic [mnrm_pkg::NOTE_W-1:0]  offset;
  logic [mnrm_pkg::RANGE_W-1:0] span;
  logic                         last;
} trig_t;

// Track the range table and the triggers still owed on the output
class range_trigger_board;
  logic [mnrm_pkg::MASK_W-1:0]  mask;
  logic [mnrm_pkg::NOTE_W-1:0]  lo[TABLE_SIZE];
  logic [mnrm_pkg::NOTE_W-1:0]  hi[TABLE_SIZE];
  logic [mnrm_pkg::ENTRY_W-1:0] learn_sel;
  bit                           want_high;
  trig_t                        due_triggers[$];
  int                           errors;

  function new();
    mask = mnrm_pkg::MASK_RESET;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      lo[i] = mnrm_pkg::EMPTY_LOW;
      hi[i] = mnrm_pkg::EMPTY_HIGH;
    end
    lo[mnrm_pkg::ENTRY_KICK]  = mnrm_pkg::KICK_NOTE;
    hi[mnrm_pkg::ENTRY_KICK]  = mnrm_pkg::KICK_NOTE;
    lo[mnrm_pkg::ENTRY_SNARE] = mnrm_pkg::SNARE_NOTE;
    hi[mnrm_pkg::ENTRY_SNARE] = mnrm_pkg::SNARE_NOTE;
    lo[mnrm_pkg::ENTRY_SMP_A] = mnrm_pkg::SMP_A_LOW;
    hi[mnrm_pkg::ENTRY_SMP_A] = mnrm_pkg::SMP_A_HIGH;
    lo[mnrm_pkg::ENTRY_SMP_B] = mnrm_pkg::SMP_B_LOW;
    hi[mnrm_pkg::ENTRY_SMP_B] = mnrm_pkg::SMP_B_HIGH;
    learn_sel = '0;
    want_high = 1'b0;
    errors = 0;
  endfunction

  function void load_mask(logic [mnrm_pkg::MASK_W-1:0] m);
    mask = m;
  endfunction

  // Apply one accepted input word and queue the triggers it causes
  function void take_word(in_word_t w);
    logic [mnrm_pkg::NOTE_W-1:0] t;
    trig_t held;
    bit    have;
    have = 1'b0;
    if (w.cmd == mnrm_pkg::CMD_SELECT) begin
      if (w.learn == MODE_LEARN && w.sel < TABLE_SIZE) begin
        learn_sel = w.sel;
        want_high = 1'b0;
      end
      return;
    end
    if (w.learn == MODE_LEARN) begin
      if (learn_sel >= TABLE_SIZE) return;
      if (!want_high) begin
        lo[learn_sel] = w.note;
        hi[learn_sel] = w.note;
        want_high = 1'b1;
      end else begin
        hi[learn_sel] = w.note;
        if (lo[learn_sel] > hi[learn_sel]) begin
          t = lo[learn_sel];
          lo[learn_sel] = hi[learn_sel];
          hi[learn_sel] = t;
        end
      end
      return;
    end
    // Scan in ascending order; hold each hit back so the final one can be marked
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (i < mnrm_pkg::MASK_W && mask[i] && w.note >= lo[i] && w.note <= hi[i]) begin
        if (have) due_triggers.push_back(held);
        held.entry  = mnrm_pkg::ENTRY_W'(i);
        held.offset = w.note - lo[i];
        held.span   = {1'b0, hi[i]} - {1'b0, lo[i]} + 8'd1;
        held.last   = 1'b0;
        have = 1'b1;
      end
    end
    if (have) begin
      held.last = 1'b1;
      due_triggers.push_back(held);
    end
  endfunction

  // Compare one accepted trigger with the oldest one owed
  function void check_trigger(trig_t got);
    trig_t want;
    if (due_triggers.size() == 0) begin
      $error("unexpected trigger: entry %0d offset %0d range %0d last %0d",
             got.entry, got.offset, got.span, got.last);
      errors++;
      return;
    end
    want = due_triggers.pop_front();
    if (got.entry !== want.entry) begin
      $error("entry: expected %0d, got %0d", want.entry, got.entry);
      errors++;
    end
    if (got.offset !== want.offset) begin
      $error("note_offset: expected %0d, got %0d", want.offset, got.offset);
      errors++;
    end
    if (got.span !== want.span) begin
      $error("note_range: expected %0d, got %0d", want.span, got.span);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module midi_note_range_mapper_core_test;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = TABLE_SIZE + 6;
  localparam int PHASE_ITEMS    = 44;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mnrm_pkg::MASK_W-1:0]   cfg_voice_present_mask = mnrm_pkg::MASK_RESET;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_cmd = mnrm_pkg::CMD_NOTE_ON;
  logic [mnrm_pkg::NOTE_W-1:0]   in_note = '0;
  logic                          in_learn_mode = MODE_PLAY;
  logic [mnrm_pkg::ENTRY_W-1:0]  in_entry_select = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mnrm_pkg::ENTRY_W-1:0]  out_entry;
  logic [mnrm_pkg::NOTE_W-1:0]   out_note_offset;
  logic [mnrm_pkg::RANGE_W-1:0]  out_note_range;
  logic                          out_last;

  logic no_idle  = 1'b0;
  logic hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  range_trigger_board triggers = new();

  midi_note_range_mapper_core #(
    .NUM_ENTRIES(TABLE_SIZE)
  ) u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_voice_present_mask (cfg_voice_present_mask),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_cmd                 (in_cmd),
    .in_note                (in_note),
    .in_learn_mode          (in_learn_mode),
    .in_entry_select        (in_entry_select),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_entry              (out_entry),
    .out_note_offset        (out_note_offset),
    .out_note_range         (out_note_range),
    .out_last               (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check accepted triggers and drive out_ready: random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      triggers.check_trigger({out_entry, out_note_offset, out_note_range, out_last});
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 16);
    end
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic in_word_t play(logic [mnrm_pkg::NOTE_W-1:0] n);
    return '{cmd: mnrm_pkg::CMD_NOTE_ON, note: n, learn: MODE_PLAY,
             sel: mnrm_pkg::ENTRY_W'($urandom)};
  endfunction

  function automatic in_word_t teach(logic [mnrm_pkg::NOTE_W-1:0] n);
    return '{cmd: mnrm_pkg::CMD_NOTE_ON, note: n, learn: MODE_LEARN,
             sel: mnrm_pkg::ENTRY_W'($urandom)};
  endfunction

  function automatic in_word_t choose(logic [mnrm_pkg::ENTRY_W-1:0] s, logic mode);
    return '{cmd: mnrm_pkg::CMD_SELECT, note: mnrm_pkg::NOTE_W'($urandom),
             learn: mode, sel: s};
  endfunction

  // Mostly aim notes inside a known range so triggers are frequent
  function automatic logic [mnrm_pkg::NOTE_W-1:0] aimed_note();
    int e;
    e = $urandom_range(TABLE_SIZE - 1);
    if ($urandom_range(3) == 0 || triggers.lo[e] > triggers.hi[e])
      return mnrm_pkg::NOTE_W'($urandom_range(127));
    return mnrm_pkg::NOTE_W'($urandom_range(triggers.hi[e], triggers.lo[e]));
  endfunction

  // Offer one word, with random gaps, and hold it until accepted
  task automatic send_word(in_word_t w);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= w.cmd;
    in_note         <= w.note;
    in_learn_mode   <= w.learn;
    in_entry_select <= w.sel;
    do @(posedge clk); while (!in_ready);
    triggers.take_word(w);
  endtask

  // Drain the block, let it settle, then write the voice mask
  task automatic write_mask(logic [mnrm_pkg::MASK_W-1:0] m);
    in_valid <= 1'b0;
    while (triggers.due_triggers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid              <= 1'b1;
    cfg_voice_present_mask <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    triggers.load_mask(m);
  endtask

  // Mix of play notes, learn sequences and ignored or broken words
  task automatic random_items(int n);
    int count;
    int r;
    int k;
    count = 0;
    while (count < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_word(play(aimed_note()));
        count++;
      end else if (r < 75) begin
        send_word(choose(mnrm_pkg::ENTRY_W'($urandom_range(TABLE_SIZE - 1)), MODE_LEARN));
        k = $urandom_range(3, 1);
        for (int j = 0; j < k; j++) begin
          if (j == 0 || $urandom_range(1) == 0)
            send_word(teach(mnrm_pkg::NOTE_W'($urandom_range(127))));
          else
            send_word(teach(mnrm_pkg::NOTE_W'(int'(triggers.lo[triggers.learn_sel]) +
                                              $urandom_range(12))));
        end
        count += 1 + k;
      end else if (r < 82) begin
        send_word(teach(mnrm_pkg::NOTE_W'($urandom_range(127))));
        count++;
      end else if (r < 90) begin
        send_word(choose(mnrm_pkg::ENTRY_W'($urandom), MODE_PLAY));
        count++;
      end else begin
        send_word(choose(mnrm_pkg::ENTRY_W'($urandom_range(15, TABLE_SIZE)), MODE_LEARN));
        count++;
      end
    end
  endtask

  initial begin
    logic [mnrm_pkg::MASK_W-1:0] phase_masks[9];
    phase_masks = '{9'h1FF, 9'h000, 9'h155, 9'h0AA, mnrm_pkg::MASK_W'($urandom),
                    9'h100, 9'h001, mnrm_pkg::MASK_W'($urandom), 9'h1FF};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Presets, empty ranges, no-match notes and ignored selects
    send_word(play(mnrm_pkg::KICK_NOTE));
    send_word(play(mnrm_pkg::SNARE_NOTE));
    send_word(play(7'd75));
    send_word(play(mnrm_pkg::SMP_B_LOW));
    send_word(play(7'd0));
    send_word(play(7'd127));
    send_word(choose(4'd5, MODE_PLAY));
    send_word(choose(4'd9, MODE_LEARN));
    send_word(choose(4'd15, MODE_LEARN));
    // Teach the last entry the full note range, high note first to force a swap
    send_word(choose(4'd8, MODE_LEARN));
    send_word(teach(7'd127));
    send_word(teach(7'd0));
    send_word(play(7'd0));
    send_word(play(7'd127));
    send_word(play(mnrm_pkg::KICK_NOTE));
    // Overlapping learned range, then a single-note range
    send_word(choose(4'd2, MODE_LEARN));
    send_word(teach(7'd70));
    send_word(teach(7'd77));
    send_word(play(7'd75));
    send_word(choose(4'd5, MODE_LEARN));
    send_word(teach(7'd60));
    send_word(teach(7'd60));
    send_word(play(7'd60));

    for (int p = 0; p < 9; p++) begin
      write_mask(phase_masks[p]);
      no_idle <= (p == 2);
      if (p == 0) begin
        // Make every entry cover the middle notes so one note fires them all
        for (int e = 0; e < TABLE_SIZE; e++) begin
          send_word(choose(mnrm_pkg::ENTRY_W'(e), MODE_LEARN));
          send_word(teach(mnrm_pkg::NOTE_W'(e * 7)));
          send_word(teach(mnrm_pkg::NOTE_W'(127 - e * 7)));
        end
        send_word(play(7'd60));
        send_word(play(7'd64));
        hold_req <= 1'b1;
        for (int j = 0; j < 12; j++)
          send_word(play(mnrm_pkg::NOTE_W'($urandom_range(70, 56))));
      end
      random_items(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (triggers.due_triggers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (triggers.due_triggers.size() != 0) begin
      $error("%0d triggers never arrived", triggers.due_triggers.size());
      triggers.errors++;
    end
    if (triggers.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hdl/mnrm_pkg.sv
hdl/mnrm_ctrl.sv
hdl/mnrm_dp.sv
hdl/midi_note_range_mapper_core.sv
sim/midi_note_range_mapper_core_test.sv
